@@ sv/tpd_pkg.sv @@
// Package for the two-way priority dispatch arbiter.
// Holds shared constants, the controller state type and the command/status structs.
`default_nettype none
package tpd_pkg;

  localparam int unsigned FifoDepthDef = 16;
  localparam int unsigned IdBitsDef    = 8;
  localparam int unsigned KeyBitsDef   = 16;
  localparam int unsigned OutIdBits    = 8;

  localparam logic OpEnqueue = 1'b0;
  localparam logic OpGrant   = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StSelect,
    StScan,
    StShift,
    StDone
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the input transaction
    logic enq_write; // store the entry or flag full
    logic sel_queue; // latch the first nonempty queue in grant order
    logic scan_step; // compare one entry and advance
    logic shift_step;// move one entry down and advance
    logic finish;    // update count and last direction
  } tpd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_grant;
    logic none_ready;
    logic scan_last;
    logic shift_last;
  } tpd_sts_t;

endpackage
`default_nettype wire

@@ sv/two_way_priority_dispatch_arbiter_unit.sv @@
// Two-way priority dispatch arbiter, top level.
// Enqueue: load, then store in the selected state, then the result strobe. Grant: a
// tie scan over the queue, then the entries behind the pick shifted down one at a time
// (one memory read per cycle); an empty grant goes straight to the result strobe.
// One transaction at a time; busy_o is high until the result strobe, and the receiver
// cannot stall. Asynchronous active-low reset empties all queues and clears the last direction.
`default_nettype none
module two_way_priority_dispatch_arbiter_unit
  import tpd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDef,
  parameter int unsigned ID_BITS    = IdBitsDef,
  parameter int unsigned KEY_BITS   = KeyBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  output logic                     done_o,
  input  wire logic                operation_i,
  input  wire logic                going_west_i,
  input  wire logic                high_priority_i,
  input  wire logic [ID_BITS-1:0]  requester_id_i,
  input  wire logic [KEY_BITS-1:0] load_key_i,
  output logic                     enqueue_done_o,
  output logic                     queue_full_o,
  output logic                     grant_valid_o,
  output logic [OutIdBits-1:0]     granted_id_o,
  output logic                     granted_west_o,
  output logic                     granted_high_o
);

  tpd_cmd_t cmd;
  tpd_sts_t sts;

  tpd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  tpd_datapath #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .ID_BITS   (ID_BITS),
    .KEY_BITS  (KEY_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (operation_i),
    .going_west_i   (going_west_i),
    .high_priority_i(high_priority_i),
    .requester_id_i (requester_id_i),
    .load_key_i     (load_key_i),
    .sts_o          (sts),
    .enqueue_done_o (enqueue_done_o),
    .queue_full_o   (queue_full_o),
    .grant_valid_o  (grant_valid_o),
    .granted_id_o   (granted_id_o),
    .granted_west_o (granted_west_o),
    .granted_high_o (granted_high_o)
  );

endmodule
`default_nettype wire

@@ sv/tpd_ctrl.sv @@
// Controller state machine for the dispatch arbiter.
// Depends on tpd_pkg; drives commands into tpd_datapath.
`default_nettype none
module tpd_ctrl
  import tpd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire tpd_sts_t sts_i,
  output tpd_cmd_t      cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (start_i) state_d = StSelect;
      StSelect: begin
        if (!sts_i.is_grant || sts_i.none_ready) state_d = StDone;
        else state_d = StScan;
      end
      StScan:   if (sts_i.scan_last) state_d = StShift;
      StShift:  if (sts_i.shift_last) state_d = StDone;
      StDone:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      StSelect: begin
        cmd_o.enq_write = !sts_i.is_grant;
        cmd_o.sel_queue = sts_i.is_grant;
      end
      StScan:  cmd_o.scan_step = 1'b1;
      StShift: begin
        cmd_o.shift_step = 1'b1;
        cmd_o.finish     = sts_i.shift_last;
      end
      StDone:  done_o = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

`ifndef ASSERT_OFF
  a_done_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) != StIdle && $past(state_q) != StDone)
    else $error("done without work");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("start not taken");
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("done not followed by idle");
`endif

endmodule
`default_nettype wire

@@ sv/tpd_datapath.sv @@
// Datapath for the dispatch arbiter: four FIFOs in one memory, counts, tie search.
// Depends on tpd_pkg; commanded by tpd_ctrl.
`default_nettype none
module tpd_datapath
  import tpd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDef,
  parameter int unsigned ID_BITS    = IdBitsDef,
  parameter int unsigned KEY_BITS   = KeyBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tpd_cmd_t             cmd_i,
  input  wire logic                 operation_i,
  input  wire logic                 going_west_i,
  input  wire logic                 high_priority_i,
  input  wire logic [ID_BITS-1:0]   requester_id_i,
  input  wire logic [KEY_BITS-1:0]  load_key_i,
  output tpd_sts_t                  sts_o,
  output logic                      enqueue_done_o,
  output logic                      queue_full_o,
  output logic                      grant_valid_o,
  output logic [OutIdBits-1:0]      granted_id_o,
  output logic                      granted_west_o,
  output logic                      granted_high_o
);

  localparam int unsigned PtrBits = $clog2(FIFO_DEPTH);
  localparam int unsigned CntBits = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned EntBits = ID_BITS + KEY_BITS;
  localparam int unsigned MemDepth = 4 * (1 << PtrBits);

  // Entry layout: {id, key}.
  logic [EntBits-1:0] mem_q [MemDepth];
  logic [CntBits-1:0] cnt_q [4];
  logic               last_west_q;

  logic               op_q, west_q, high_q;
  logic [ID_BITS-1:0] id_q;
  logic [KEY_BITS-1:0] key_q;
  logic [1:0]         qsel_q;
  logic [CntBits-1:0] idx_q;
  logic [PtrBits-1:0] pick_q;
  logic [ID_BITS-1:0] best_id_q;
  logic [KEY_BITS-1:0] head_key_q;
  logic [CntBits-1:0] n_q;
  logic               first_q;
  logic               ok_q, full_q, gv_q;
  logic [ID_BITS-1:0] gid_q;
  logic               gw_q, gh_q;

  // Entry read at the current index of the selected queue (registered read).
  logic [EntBits-1:0] rd_q;

  logic [1:0] qin;
  assign qin = {west_q, high_q};

  // Grant order selection.
  logic [1:0] ord [4];
  logic [1:0] first_q_sel;
  logic       found;
  always_comb begin
    if (last_west_q) begin
      ord[0] = 2'd1; ord[1] = 2'd3; ord[2] = 2'd0; ord[3] = 2'd2;
    end else begin
      ord[0] = 2'd3; ord[1] = 2'd1; ord[2] = 2'd2; ord[3] = 2'd0;
    end
    found       = 1'b0;
    first_q_sel = ord[0];
    for (int k = 3; k >= 0; k--) begin
      if (cnt_q[ord[k]] != '0) begin
        found       = 1'b1;
        first_q_sel = ord[k];
      end
    end
  end

  logic [CntBits-1:0] idx_ext;
  assign idx_ext = idx_q;

  assign sts_o.is_grant   = op_q == OpGrant;
  assign sts_o.none_ready = !found;
  // The scan reads entry idx in the cycle before it is compared: rd_q holds idx-1.
  // The head alone is the last compare for a single-entry queue.
  assign sts_o.scan_last  = first_q ? (n_q == CntBits'(1)) : (idx_ext >= n_q);
  assign sts_o.shift_last = (CntBits'(pick_q) + 1'b1) >= n_q;

  logic [PtrBits-1:0] rd_addr;
  always_comb begin
    if (cmd_i.sel_queue) begin
      rd_addr = '0;
    end else if (cmd_i.shift_step) begin
      rd_addr = pick_q + 1'b1;
    end else begin
      rd_addr = idx_q[PtrBits-1:0];
    end
  end

  logic [$clog2(MemDepth)-1:0] wr_addr;
  logic [EntBits-1:0]          wr_data;
  logic                        wr_en;
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {qin, cnt_q[qin][PtrBits-1:0]};
    wr_data = {id_q, key_q};
    if (cmd_i.enq_write && cnt_q[qin] < CntBits'(FIFO_DEPTH)) begin
      wr_en = 1'b1;
    end else if (cmd_i.shift_step && !sts_o.shift_last && !first_q) begin
      wr_en   = 1'b1;
      wr_addr = {qsel_q, pick_q};
      wr_data = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[{(cmd_i.sel_queue ? first_q_sel : qsel_q), rd_addr}];
  end

  logic [ID_BITS-1:0]  rd_id;
  logic [KEY_BITS-1:0] rd_key;
  assign rd_id  = rd_q[EntBits-1:KEY_BITS];
  assign rd_key = rd_q[KEY_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      west_q <= going_west_i;
      high_q <= high_priority_i;
      id_q   <= requester_id_i;
      key_q  <= load_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < 4; q++) cnt_q[q] <= '0;
      last_west_q <= 1'b0;
      ok_q <= 1'b0; full_q <= 1'b0; gv_q <= 1'b0;
      gid_q <= '0; gw_q <= 1'b0; gh_q <= 1'b0;
      qsel_q <= '0; idx_q <= '0; pick_q <= '0; n_q <= '0; first_q <= 1'b0;
      best_id_q <= '0; head_key_q <= '0;
    end else begin
      if (cmd_i.load) begin
        ok_q <= 1'b0; full_q <= 1'b0; gv_q <= 1'b0;
        gid_q <= '0; gw_q <= 1'b0; gh_q <= 1'b0;
      end
      if (cmd_i.enq_write) begin
        if (cnt_q[qin] < CntBits'(FIFO_DEPTH)) begin
          cnt_q[qin] <= cnt_q[qin] + 1'b1;
          ok_q       <= 1'b1;
        end else begin
          full_q <= 1'b1;
        end
      end
      if (cmd_i.sel_queue) begin
        // Entry 0 is being read now; the scan starts at index 1.
        qsel_q  <= first_q_sel;
        n_q     <= cnt_q[first_q_sel];
        idx_q   <= CntBits'(1);
        pick_q  <= '0;
        first_q <= 1'b1;
      end
      if (cmd_i.scan_step) begin
        // On the last compare, arm the first shift cycle, which only issues a read.
        first_q <= sts_o.scan_last;
        if (first_q) begin
          head_key_q <= rd_key;
          best_id_q  <= rd_id;
        end else if (rd_key == head_key_q && rd_id < best_id_q) begin
          best_id_q <= rd_id;
          pick_q    <= PtrBits'(idx_q - 1'b1);
        end
        if (!sts_o.scan_last) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (cmd_i.shift_step) begin
        if (first_q) begin
          first_q <= 1'b0;
        end else if (!sts_o.shift_last) begin
          pick_q <= pick_q + 1'b1;
          first_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        cnt_q[qsel_q] <= n_q - 1'b1;
        last_west_q   <= qsel_q[1];
        gv_q          <= 1'b1;
        gid_q         <= best_id_q;
        gw_q          <= qsel_q[1];
        gh_q          <= qsel_q[0];
      end
    end
  end

  assign enqueue_done_o = ok_q;
  assign queue_full_o   = full_q;
  assign grant_valid_o  = gv_q;
  assign granted_west_o = gw_q;
  assign granted_high_o = gh_q;
  always_comb begin
    granted_id_o = '0;
    for (int b = 0; b < OutIdBits; b++) begin
      if (b < ID_BITS) granted_id_o[b] = gid_q[b];
    end
  end

`ifndef ASSERT_OFF
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((ok_q || full_q) && gv_q))
    else $error("enqueue and grant flags together");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= CntBits'(FIFO_DEPTH) && cnt_q[1] <= CntBits'(FIFO_DEPTH) &&
    cnt_q[2] <= CntBits'(FIFO_DEPTH) && cnt_q[3] <= CntBits'(FIFO_DEPTH))
    else $error("fifo count overflow");
  a_finish_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> n_q != '0)
    else $error("grant from empty queue");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for the two-way priority dispatch arbiter: directed table, then random traffic.
// Depends on tpd_pkg and two_way_priority_dispatch_arbiter_unit; checks every strobe.
`timescale 1ns / 1ps
module tb_top;
  import tpd_pkg::*;

  localparam int unsigned Depth = FifoDepthDef;
  localparam int unsigned CycleLimit = 600000;

  typedef struct packed {
    logic       enq_done;
    logic       full;
    logic       gvalid;
    logic [7:0] gid;
    logic       gwest;
    logic       ghigh;
  } arb_result_t;

  typedef struct packed {
    logic        op;
    logic        west;
    logic        high;
    logic [7:0]  id;
    logic [15:0] key;
  } arb_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic operation_i = 1'b0, going_west_i = 1'b0, high_priority_i = 1'b0;
  logic [7:0] requester_id_i = '0;
  logic [15:0] load_key_i = '0;
  logic busy_o, done_o, enqueue_done_o, queue_full_o, grant_valid_o;
  logic [7:0] granted_id_o;
  logic granted_west_o, granted_high_o;

  two_way_priority_dispatch_arbiter_unit DUT (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Predictor state
  logic [7:0]  q_id  [4][Depth];
  logic [15:0] q_key [4][Depth];
  int unsigned q_cnt [4];
  logic        last_west;
  arb_result_t pending_results[$];
  int unsigned errors = 0, n_items = 0, n_grants = 0, n_full = 0, cycles = 0;
  int          gap_pct = 0;

  function automatic arb_result_t arbitrate(arb_cmd_t c);
    arb_result_t r;
    int q, n, pick;
    int ord[4];
    r = '0;
    if (c.op == OpEnqueue) begin
      q = c.west * 2 + c.high;
      if (q_cnt[q] >= Depth) r.full = 1'b1;
      else begin
        q_id[q][q_cnt[q]] = c.id;
        q_key[q][q_cnt[q]] = c.key;
        q_cnt[q]++;
        r.enq_done = 1'b1;
      end
      return r;
    end
    if (last_west) ord = '{1, 3, 0, 2};
    else ord = '{3, 1, 2, 0};
    for (int k = 0; k < 4; k++) begin
      q = ord[k];
      n = q_cnt[q];
      if (n == 0) continue;
      pick = 0;
      for (int i = 1; i < n; i++)
        if (q_key[q][i] == q_key[q][0] && q_id[q][i] < q_id[q][pick]) pick = i;
      r.gvalid = 1'b1;
      r.gid = q_id[q][pick];
      r.gwest = q[1];
      r.ghigh = q[0];
      for (int i = pick; i + 1 < n; i++) begin
        q_id[q][i] = q_id[q][i+1];
        q_key[q][i] = q_key[q][i+1];
      end
      q_cnt[q]--;
      last_west = q[1];
      break;
    end
    return r;
  endfunction

  // Check every strobe
  always @(posedge clk_i) begin
    arb_result_t got, want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("[two_way_priority_dispatch_arbiter_unit] ERROR");
      $finish;
    end
    if (rst_ni && done_o) begin
      got = '{enqueue_done_o, queue_full_o, grant_valid_o, granted_id_o,
              granted_west_o, granted_high_o};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  task automatic send(arb_cmd_t c, bit typed, arb_result_t typed_res);
    arb_result_t p;
    while ($urandom_range(99) < gap_pct) @(negedge clk_i);
    // Hold until the previous transaction has finished
    while (busy_o) @(negedge clk_i);
    operation_i <= c.op; going_west_i <= c.west; high_priority_i <= c.high;
    requester_id_i <= c.id; load_key_i <= c.key;
    start_i <= 1'b1;
    @(posedge clk_i);
    p = arbitrate(c);
    if (typed && p !== typed_res) begin
      $display("%0t table row disagrees: expected %h predicted %h", $time, typed_res, p);
      errors++;
    end
    pending_results.push_back(p);
    if (c.op == OpGrant && p.gvalid) n_grants++;
    if (p.full) n_full++;
    n_items++;
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  typedef struct packed {
    arb_cmd_t    cmd;
    bit          typed;
    arb_result_t res;
  } table_row_t;

  arb_result_t EnqOk   = '{1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0};
  arb_result_t EnqFull = '{1'b0, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0};
  arb_result_t NoGrant = '0;

  initial begin
    table_row_t rows[$];
    arb_cmd_t c;
    int mode;
    for (int q = 0; q < 4; q++) q_cnt[q] = 0;
    last_west = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty grant, extremes, ties, order flip
    rows.push_back('{'{OpGrant, 1'b1, 1'b1, 8'hFF, 16'hFFFF}, 1'b1, NoGrant});
    rows.push_back('{'{OpEnqueue, 1'b0, 1'b0, 8'd0, 16'd0}, 1'b1, EnqOk});
    rows.push_back('{'{OpEnqueue, 1'b1, 1'b1, 8'hFF, 16'hFFFF}, 1'b1, EnqOk});
    rows.push_back('{'{OpEnqueue, 1'b1, 1'b1, 8'h20, 16'h1234}, 1'b1, EnqOk});
    rows.push_back('{'{OpEnqueue, 1'b1, 1'b1, 8'h10, 16'hFFFF}, 1'b1, EnqOk});
    rows.push_back('{'{OpEnqueue, 1'b1, 1'b1, 8'h10, 16'hFFFF}, 1'b1, EnqOk});
    rows.push_back('{'{OpEnqueue, 1'b0, 1'b1, 8'h05, 16'h0001}, 1'b1, EnqOk});
    rows.push_back('{'{OpGrant, 1'b0, 1'b0, 8'd0, 16'd0}, 1'b1,
                     '{1'b0, 1'b0, 1'b1, 8'h10, 1'b1, 1'b1}});
    rows.push_back('{'{OpGrant, 1'b0, 1'b0, 8'd0, 16'd0}, 1'b1,
                     '{1'b0, 1'b0, 1'b1, 8'h05, 1'b0, 1'b1}});
    for (int i = 0; i < 4; i++)
      rows.push_back('{'{OpGrant, 1'b0, 1'b0, 8'd0, 16'd0}, 1'b0, NoGrant});
    rows.push_back('{'{OpGrant, 1'b0, 1'b0, 8'd0, 16'd0}, 1'b1, NoGrant});
    for (int i = 0; i < 16; i++)
      rows.push_back('{'{OpEnqueue, 1'b0, 1'b0, 8'(255 - i), 16'h00AA}, 1'b1, EnqOk});
    rows.push_back('{'{OpEnqueue, 1'b0, 1'b0, 8'h00, 16'h00AA}, 1'b1, EnqFull});
    foreach (rows[i]) send(rows[i].cmd, rows[i].typed, rows[i].res);
    drain();
    // Empty the last directed queue before random traffic
    for (int i = 0; i < 16; i++) send('{OpGrant, 1'b0, 1'b0, 8'd0, 16'd0}, 1'b0, NoGrant);
    drain();

    for (int item = 0; item < 1750; item++) begin
      case ((item / 300) % 4)
        0: gap_pct = 0;
        1: gap_pct = 70;
        2: gap_pct = 28;
        default: gap_pct = 0;
      endcase
      // Hold off once until everything has come back
      if (item == 900) drain();
      mode = $urandom_range(99);
      c.op = (mode < 55) ? OpEnqueue : OpGrant;
      c.west = 1'($urandom_range(1));
      c.high = 1'($urandom_range(1));
      c.id = (mode % 3 == 0) ? 8'($urandom_range(7)) : 8'($urandom);
      c.key = (mode % 2 == 0) ? 16'($urandom_range(2)) : 16'($urandom);
      send(c, 1'b0, NoGrant);
    end
    start_i <= 1'b0;
    drain();
    $display("ran %0d transactions, %0d grants served, %0d dropped on a full queue",
             n_items, n_grants, n_full);
    if (errors == 0 && pending_results.size() == 0)
      $display("[two_way_priority_dispatch_arbiter_unit] OK");
    else
      $display("[two_way_priority_dispatch_arbiter_unit] ERROR");
    $finish;
  end
endmodule

@@ sim.f @@
sv/tpd_pkg.sv
sv/tpd_ctrl.sv
sv/tpd_datapath.sv
sv/two_way_priority_dispatch_arbiter_unit.sv
tb/sv/tb_top.sv
